// File: rtl/dpbp_pkg.sv
package dpbp_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    localparam logic [1:0] MIN_POINTS = 2'd3;

    localparam logic signed [47:0] SAT_POS = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SAT_NEG = 48'sh8000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_STEP = 3'd0,
        REG_CENTER_X    = 3'd1,
        REG_CENTER_Y    = 3'd2,
        REG_X_GAIN      = 3'd3,
        REG_Y_GAIN      = 3'd4,
        REG_DEPTH_GAIN  = 3'd5,
        REG_MIN_RAW     = 3'd6,
        REG_MAX_RAW     = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] depth_raw;
        logic        row_end;
        logic        frame_end;
    } pix_in_t;

    typedef struct packed {
        logic signed [47:0] point_x;
        logic signed [47:0] point_y;
        logic [31:0]        point_z;
        logic               point_valid;
        logic               frame_done;
        logic               too_few_points;
    } point_out_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic z_en;
        logic pmul_en;
        logic split_en;
        logic round_en;
        logic out_load;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic emit;
    } dp_status_t;

    function automatic logic [7:0] next_phase(input logic [7:0] ph, input logic [7:0] step);
        logic [8:0] inc;
        inc = {1'b0, ph} + 9'd1;
        return (inc >= {1'b0, step}) ? 8'd0 : inc[7:0];
    endfunction

endpackage

// File: rtl/dpbp_ctrl.sv
module dpbp_ctrl
    import dpbp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ZMUL  = 6'b000010,
        ST_PMUL  = 6'b000100,
        ST_SPLIT = 6'b001000,
        ST_ROUND = 6'b010000,
        ST_EMIT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.capture  = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.emit)
                begin
                    state_next = ST_ZMUL;
                end
            end
            ST_ZMUL:
            begin
                cmd.z_en   = 1'b1;
                state_next = ST_PMUL;
            end
            ST_PMUL:
            begin
                cmd.pmul_en = 1'b1;
                state_next  = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                cmd.split_en = 1'b1;
                state_next   = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.out_load)
        else $error("result register overwritten while held");

    // an emitting transaction starts the arithmetic sequence
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.emit) |=> (state_reg == ST_ZMUL))
        else $error("emitting transaction did not start computation");

    // a dropped pixel leaves the block ready
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !status.emit) |=> in_ready)
        else $error("dropped pixel stalled the input");

    // load only after the rounding step
    a_load_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (state_reg == ST_EMIT))
        else $error("result loaded outside emit state");

endmodule

// File: rtl/dpbp_datapath.sv
module dpbp_datapath
    import dpbp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pix_in_t               in_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output point_out_t            out_data
);

    localparam int COL_W = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);

    // configuration registers
    logic [7:0]  sample_step_reg;
    logic [15:0] center_x_reg, center_y_reg, min_raw_reg, max_raw_reg;
    logic [24:0] x_gain_reg, y_gain_reg, depth_gain_reg;

    // position tracking
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [7:0]       col_phase_reg, col_phase_next, row_phase_reg, row_phase_next;
    logic [1:0]       tally_reg, tally_next, tally_inc;

    // captured item
    logic [15:0] raw_reg;
    logic        keep_reg, fe_reg, few_reg;
    logic        negx_reg, negy_reg;
    logic [15:0] magx_reg, magy_reg;

    // arithmetic pipeline registers
    logic [31:0] z_reg;
    logic [47:0] mzx_reg, mzy_reg;
    logic [48:0] hix_reg, lox_reg, hiy_reg, loy_reg;
    logic [45:0] rx_reg, ry_reg;
    point_out_t  out_reg;

    logic [7:0]         step_eff;
    logic               keep;
    logic signed [16:0] dx, dy;
    logic [16:0]        adx, ady;
    logic [40:0]        zprod;
    logic [49:0]        sumx, sumy;
    logic signed [47:0] sx, sy;

    function automatic logic signed [47:0] sign_sat(input logic neg, input logic [45:0] r);
        logic [48:0] rw;
        rw = {3'b000, r};
        if (neg)
        begin
            return (rw > 49'h0_8000_0000_0000) ? SAT_NEG : -$signed({2'b00, r});
        end
        return (rw > 49'h0_7FFF_FFFF_FFFF) ? SAT_POS : $signed({2'b00, r});
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_step_reg <= 8'd1;
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            x_gain_reg      <= '0;
            y_gain_reg      <= '0;
            depth_gain_reg  <= 25'h100_0000;
            min_raw_reg     <= '0;
            max_raw_reg     <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SAMPLE_STEP: sample_step_reg <= cfg_data[7:0];
                REG_CENTER_X:    center_x_reg    <= cfg_data[15:0];
                REG_CENTER_Y:    center_y_reg    <= cfg_data[15:0];
                REG_X_GAIN:      x_gain_reg      <= cfg_data;
                REG_Y_GAIN:      y_gain_reg      <= cfg_data;
                REG_DEPTH_GAIN:  depth_gain_reg  <= cfg_data;
                REG_MIN_RAW:     min_raw_reg     <= cfg_data[15:0];
                REG_MAX_RAW:     max_raw_reg     <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    assign step_eff = (sample_step_reg == 8'd0) ? 8'd1 : sample_step_reg;
    assign keep     = (col_phase_reg == 8'd0) && (row_phase_reg == 8'd0)
                      && (in_data.depth_raw >= min_raw_reg)
                      && (in_data.depth_raw <= max_raw_reg);
    assign status.emit = keep || in_data.frame_end;

    assign tally_inc = (keep && (tally_reg < MIN_POINTS)) ? tally_reg + 2'd1 : tally_reg;

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        col_phase_next = col_phase_reg;
        row_phase_next = row_phase_reg;
        tally_next     = tally_inc;
        if (in_data.frame_end)
        begin
            col_next       = '0;
            row_next       = '0;
            col_phase_next = '0;
            row_phase_next = '0;
            tally_next     = '0;
        end
        else if (in_data.row_end)
        begin
            col_next       = '0;
            col_phase_next = '0;
            if (row_reg < ROW_LAST)
            begin
                row_next = row_reg + 1'b1;
            end
            row_phase_next = next_phase(row_phase_reg, step_eff);
        end
        else
        begin
            if (col_reg < COL_LAST)
            begin
                col_next = col_reg + 1'b1;
            end
            col_phase_next = next_phase(col_phase_reg, step_eff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            col_phase_reg <= '0;
            row_phase_reg <= '0;
            tally_reg     <= '0;
        end
        else if (cmd.capture)
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            col_phase_reg <= col_phase_next;
            row_phase_reg <= row_phase_next;
            tally_reg     <= tally_next;
        end
    end

    // signed Q.4 offsets from the principal point
    assign dx  = $signed({1'b0, 16'(col_reg) << 4}) - $signed({1'b0, center_x_reg});
    assign dy  = $signed({1'b0, 16'(row_reg) << 4}) - $signed({1'b0, center_y_reg});
    assign adx = dx[16] ? 17'(-dx) : 17'(dx);
    assign ady = dy[16] ? 17'(-dy) : 17'(dy);

    assign zprod = 41'(raw_reg * depth_gain_reg) + 41'd128;

    assign sumx = 50'(lox_reg) + 50'(28'h800_0000) + (50'(hix_reg[3:0]) << 24);
    assign sumy = 50'(loy_reg) + 50'(28'h800_0000) + (50'(hiy_reg[3:0]) << 24);

    assign sx = sign_sat(negx_reg, rx_reg);
    assign sy = sign_sat(negy_reg, ry_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            raw_reg  <= in_data.depth_raw;
            keep_reg <= keep;
            fe_reg   <= in_data.frame_end;
            few_reg  <= (tally_inc < MIN_POINTS);
            negx_reg <= dx[16];
            negy_reg <= dy[16];
            magx_reg <= adx[15:0];
            magy_reg <= ady[15:0];
        end
        if (cmd.z_en)
        begin
            z_reg <= zprod[39:8];
        end
        if (cmd.pmul_en)
        begin
            mzx_reg <= 48'(magx_reg * z_reg);
            mzy_reg <= 48'(magy_reg * z_reg);
        end
        if (cmd.split_en)
        begin
            hix_reg <= 49'(mzx_reg[47:24] * x_gain_reg);
            lox_reg <= 49'(mzx_reg[23:0] * x_gain_reg);
            hiy_reg <= 49'(mzy_reg[47:24] * y_gain_reg);
            loy_reg <= 49'(mzy_reg[23:0] * y_gain_reg);
        end
        if (cmd.round_en)
        begin
            rx_reg <= 46'(hix_reg >> 4) + 46'(sumx >> 28);
            ry_reg <= 46'(hiy_reg >> 4) + 46'(sumy >> 28);
        end
        if (cmd.out_load)
        begin
            out_reg.point_x        <= keep_reg ? sx : '0;
            out_reg.point_y        <= keep_reg ? sy : '0;
            out_reg.point_z        <= keep_reg ? z_reg : '0;
            out_reg.point_valid    <= keep_reg;
            out_reg.frame_done     <= fe_reg;
            out_reg.too_few_points <= fe_reg && few_reg;
        end
    end

    assign out_data = out_reg;

    // frame end clears the position state
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && in_data.frame_end)
        |=> (col_reg == '0 && row_reg == '0 && tally_reg == '0
             && col_phase_reg == '0 && row_phase_reg == '0))
        else $error("frame end did not clear position state");

    // counters saturate at the image limits
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= COL_LAST) && (row_reg <= ROW_LAST))
        else $error("position counter beyond image limit");

    // tracking state only moves on a transaction
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.capture |=> ($stable(col_reg) && $stable(row_reg) && $stable(tally_reg)))
        else $error("position state changed without a transaction");

endmodule

// File: rtl/depth_pixel_backprojection.sv
// a kept pixel or frame end mark walks capture, z, offset*z, split gain products, rounding
// and output load, out_valid registered from the load; no new pixel is taken before that load,
// which waits while an older result is held; after a dropped pixel the block stays ready
// reset: asynchronous, active low; registers return to their documented defaults,
// position counters and point tally clear, no result pending
module depth_pixel_backprojection
    import dpbp_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // pixel input transaction
    input  logic                  in_valid,
    output logic                  in_ready,
    input  pix_in_t               in_data,
    // point result transaction
    output logic                  out_valid,
    input  logic                  out_ready,
    output point_out_t            out_data,
    // register write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: accepts a pixel when idle, walks the multiply steps for
    // pixels that produce a result, then parks the result in the output register
    dpbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: registers, raster position tracking, grid and window test,
    // fixed point back-projection and output register
    dpbp_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

// File: sim/tb_depth_pixel_backprojection.sv
`timescale 1ns / 100ps

module tb_depth_pixel_backprojection;
    import dpbp_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 10;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int LONG_STALL    = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PIXELS  = 125;
    localparam int NUM_REGS      = 1 << CFG_IDX_W;
    localparam logic [24:0] GAIN_ONE = 25'h100_0000;

    // receive side stall patterns
    typedef enum int {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_PERIODIC} sink_mode_t;

    // shadow of the block: registers, raster position and point tally per frame,
    // plus the queue of points still owed by the block
    class backprojection_scoreboard;
        logic [7:0]  step_reg;
        logic [15:0] center_x_reg;
        logic [15:0] center_y_reg;
        logic [24:0] x_gain_reg;
        logic [24:0] y_gain_reg;
        logic [24:0] depth_gain_reg;
        logic [15:0] min_raw_reg;
        logic [15:0] max_raw_reg;
        logic [11:0] column;
        logic [11:0] row;
        logic [7:0]  column_phase;
        logic [7:0]  row_phase;
        logic [1:0]  tally;
        point_out_t  pending_points[$];
        int          errors = 0;
        int          pixels = 0;
        int          points = 0;
        int          frames = 0;
        int          short_frames = 0;

        function new();
            step_reg       = 8'd1;
            center_x_reg   = '0;
            center_y_reg   = '0;
            x_gain_reg     = '0;
            y_gain_reg     = '0;
            depth_gain_reg = GAIN_ONE;
            min_raw_reg    = 16'h0000;
            max_raw_reg    = 16'hFFFF;
            column         = '0;
            row            = '0;
            column_phase   = '0;
            row_phase      = '0;
            tally          = '0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [24:0] val);
            case (idx)
                REG_SAMPLE_STEP: step_reg       = val[7:0];
                REG_CENTER_X:    center_x_reg   = val[15:0];
                REG_CENTER_Y:    center_y_reg   = val[15:0];
                REG_X_GAIN:      x_gain_reg     = val;
                REG_Y_GAIN:      y_gain_reg     = val;
                REG_DEPTH_GAIN:  depth_gain_reg = val;
                REG_MIN_RAW:     min_raw_reg    = val[15:0];
                REG_MAX_RAW:     max_raw_reg    = val[15:0];
            endcase
        endfunction

        // zero step behaves as one
        function logic [7:0] step_phase(logic [7:0] ph);
            logic [8:0] period;
            logic [8:0] nxt;
            period = (step_reg == 8'd0) ? 9'd1 : {1'b0, step_reg};
            nxt    = {1'b0, ph} + 9'd1;
            return (nxt >= period) ? 8'd0 : nxt[7:0];
        endfunction

        // (16*pos - center) * z * gain, Q.44 magnitude rounded to Q.16, then signed
        function logic [47:0] project_axis(logic [11:0] pos, logic [15:0] center,
                                           logic [31:0] z, logic [24:0] gain);
            logic signed [18:0] offset;
            logic [18:0]        mag;
            logic [127:0]       wide_mag;
            logic [127:0]       wide_z;
            logic [127:0]       wide_gain;
            logic [127:0]       scaled;
            offset    = $signed({3'b000, pos, 4'h0}) - $signed({3'b000, center});
            mag       = offset[18] ? -offset : offset;
            wide_mag  = 128'(mag);
            wide_z    = 128'(z);
            wide_gain = 128'(gain);
            scaled    = (wide_mag * wide_z * wide_gain + (128'd1 << 27)) >> 28;
            if (offset[18])
                return (scaled > 128'h8000_0000_0000) ? SAT_NEG : -scaled[47:0];
            else
                return (scaled > 128'h7FFF_FFFF_FFFF) ? SAT_POS : scaled[47:0];
        endfunction

        function void note_pixel(pix_in_t px);
            point_out_t  expected;
            logic        keep;
            logic [40:0] product;
            logic [31:0] z;
            pixels++;
            expected = '0;
            keep = column_phase == 8'd0 && row_phase == 8'd0 &&
                   px.depth_raw >= min_raw_reg && px.depth_raw <= max_raw_reg;
            if (keep)
            begin
                product              = px.depth_raw * depth_gain_reg + 41'd128;
                z                    = product[39:8];
                expected.point_z     = z;
                expected.point_x     = project_axis(column, center_x_reg, z, x_gain_reg);
                expected.point_y     = project_axis(row, center_y_reg, z, y_gain_reg);
                expected.point_valid = 1'b1;
                if (tally < MIN_POINTS)
                    tally++;
            end
            if (px.frame_end)
            begin
                expected.frame_done     = 1'b1;
                expected.too_few_points = tally < MIN_POINTS;
                column       = '0;
                row          = '0;
                column_phase = '0;
                row_phase    = '0;
                tally        = '0;
            end
            else if (px.row_end)
            begin
                column       = '0;
                column_phase = '0;
                if (row < DEF_MAX_HEIGHT - 1)
                    row++;
                row_phase = step_phase(row_phase);
            end
            else
            begin
                if (column < DEF_MAX_WIDTH - 1)
                    column++;
                column_phase = step_phase(column_phase);
            end
            if (keep || px.frame_end)
                pending_points.push_back(expected);
        endfunction

        function void compare_field(string name, logic [47:0] want, logic [47:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_point(point_out_t got);
            point_out_t want;
            if (pending_points.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual x=%h y=%h z=%h %b%b%b",
                         $time, got.point_x, got.point_y, got.point_z,
                         got.point_valid, got.frame_done, got.too_few_points);
                return;
            end
            want = pending_points.pop_front();
            compare_field("point_x", want.point_x, got.point_x);
            compare_field("point_y", want.point_y, got.point_y);
            compare_field("point_z", 48'(want.point_z), 48'(got.point_z));
            compare_field("point_valid", 48'(want.point_valid), 48'(got.point_valid));
            compare_field("frame_done", 48'(want.frame_done), 48'(got.frame_done));
            compare_field("too_few_points", 48'(want.too_few_points),
                          48'(got.too_few_points));
            if (want.point_valid)
                points++;
            if (want.frame_done)
                frames++;
            if (want.too_few_points)
                short_frames++;
        endfunction
    endclass

    // dut ports, all inputs known from time zero
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    pix_in_t               in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    point_out_t            out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    backprojection_scoreboard sb;

    // register values for the next setting, indexed by register
    logic [24:0] reg_plan [NUM_REGS];
    int          settings_applied = 0;
    int          pixels_sent = 0;
    int          burst_left = 0;
    int          max_gap = 6;
    int          stall_requests = 0;
    int          stall_served = 0;
    int          cycle_count = 0;

    depth_pixel_backprojection u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // both transactions are sampled at the edge, before any nba update lands;
    // the input is noted first so a same-edge result would still find its expectation
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_pixel(in_data);
            if (out_valid && out_ready)
                sb.check_point(out_data);
        end
    end

    // run limit
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, sb.pending_points.size());
        $display("Regression FAIL");
        $finish;
    end

    // result side: switches between stall patterns, and serves a long hold-off on request
    initial
    begin : result_sink
        sink_mode_t mode;
        int         mode_left;
        int         tick;
        mode      = SINK_OPEN;
        mode_left = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            if (stall_served != stall_requests)
            begin
                // long hold-off, counted here while the sender keeps offering
                stall_served = stall_requests;
                out_ready <= 1'b0;
                for (int n = 0; n < LONG_STALL; n++)
                    @(posedge clk);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = sink_mode_t'($urandom_range(SINK_OPEN, SINK_PERIODIC));
                    mode_left = $urandom_range(16, 200);
                end
                mode_left--;
                tick++;
                case (mode)
                    SINK_OPEN:     out_ready <= 1'b1;
                    SINK_COIN:     out_ready <= 1'($urandom_range(0, 1));
                    SINK_SLOW:     out_ready <= ($urandom_range(0, 3) == 0);
                    SINK_PERIODIC: out_ready <= (tick % 5) != 0;
                endcase
            end
        end
    end

    // write every register from reg_plan; only called while the block is idle
    task automatic apply_reg_plan();
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= reg_plan[i];
            sb.write_reg(cfg_reg_t'(i), reg_plan[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // one pixel transaction, in bursts with random gaps between them
    task automatic offer_pixel(logic [15:0] raw, logic row_last, logic frame_last);
        int      gap;
        pix_in_t px;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, max_gap);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        px.depth_raw = raw;
        px.row_end   = row_last;
        px.frame_end = frame_last;
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // sender pauses until every owed result is back, then lets the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // raw depth biased to the window and its edges
    function automatic logic [15:0] pick_raw();
        logic [15:0] lo;
        logic [15:0] hi;
        lo = reg_plan[REG_MIN_RAW][15:0];
        hi = reg_plan[REG_MAX_RAW][15:0];
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return lo;
            3:       return hi;
            4:       return lo - 16'd1;
            5:       return hi + 16'd1;
            6:       return 16'($urandom_range(0, 65535));
            default: return (lo <= hi) ? 16'($urandom_range(lo, hi))
                                       : 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // raster frame with row marks and a frame mark; some marks are scrambled
    // and some frames never get their end mark, so they run into the next one
    task automatic send_frame(int width, int height);
        bit   drop_end;
        logic row_last;
        logic frame_last;
        drop_end = ($urandom_range(0, 14) == 0);
        for (int r = 0; r < height; r++)
        begin
            for (int c = 0; c < width; c++)
            begin
                row_last   = (c == width - 1);
                frame_last = (r == height - 1) && row_last && !drop_end;
                if ($urandom_range(0, 11) == 0)
                begin
                    row_last   = 1'($urandom_range(0, 1));
                    frame_last = 1'($urandom_range(0, 1));
                end
                offer_pixel(pick_raw(), row_last, frame_last);
            end
        end
    endtask

    task automatic plan_random_setting();
        int lo;
        case ($urandom_range(0, 3))
            0:       reg_plan[REG_SAMPLE_STEP] = 25'd1;
            1:       reg_plan[REG_SAMPLE_STEP] = 25'd2;
            2:       reg_plan[REG_SAMPLE_STEP] = 25'($urandom_range(3, 5));
            default: reg_plan[REG_SAMPLE_STEP] = 25'($urandom_range(0, 255));
        endcase
        reg_plan[REG_CENTER_X]   = 25'($urandom_range(0, 65535));
        reg_plan[REG_CENTER_Y]   = 25'($urandom_range(0, 65535));
        reg_plan[REG_X_GAIN]     = 25'($urandom_range(0, GAIN_ONE));
        reg_plan[REG_Y_GAIN]     = 25'($urandom_range(0, GAIN_ONE));
        reg_plan[REG_DEPTH_GAIN] = 25'($urandom_range(0, GAIN_ONE));
        lo = $urandom_range(0, 40000);
        reg_plan[REG_MIN_RAW] = 25'(lo);
        reg_plan[REG_MAX_RAW] = ($urandom_range(0, 4) == 0) ? 25'd65535
                                                            : 25'($urandom_range(lo, 65535));
    endtask

    initial
    begin : stimulus
        int target;
        int width;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero gains give zero x and y, z is raw in meters
        offer_pixel(16'h0000, 1'b0, 1'b0);
        offer_pixel(16'hFFFF, 1'b0, 1'b0);
        offer_pixel(16'd7, 1'b1, 1'b0);
        offer_pixel(16'd1, 1'b0, 1'b1);
        drain_results();

        // full gains, center row at the top extreme so y goes negative
        reg_plan[REG_SAMPLE_STEP] = 25'd1;
        reg_plan[REG_CENTER_X]    = 25'h0020;
        reg_plan[REG_CENTER_Y]    = 25'hFFFF;
        reg_plan[REG_X_GAIN]      = GAIN_ONE;
        reg_plan[REG_Y_GAIN]      = GAIN_ONE;
        reg_plan[REG_DEPTH_GAIN]  = GAIN_ONE;
        reg_plan[REG_MIN_RAW]     = 25'h0000;
        reg_plan[REG_MAX_RAW]     = 25'hFFFF;
        apply_reg_plan();
        // 3x2 frame, last pixel carries both row and frame marks
        offer_pixel(16'hFFFF, 1'b0, 1'b0);
        offer_pixel(16'h0000, 1'b0, 1'b0);
        offer_pixel(16'd12345, 1'b1, 1'b0);
        offer_pixel(16'd1, 1'b0, 1'b0);
        offer_pixel(16'd40000, 1'b0, 1'b0);
        offer_pixel(16'h8000, 1'b1, 1'b1);
        // one-pixel frame: a single point is too few
        offer_pixel(16'd500, 1'b1, 1'b1);
        // third point sits on the frame end pixel itself
        offer_pixel(16'd100, 1'b0, 1'b0);
        offer_pixel(16'd200, 1'b0, 1'b0);
        offer_pixel(16'd300, 1'b0, 1'b1);
        drain_results();

        // empty window: minimum above maximum drops everything
        reg_plan[REG_SAMPLE_STEP] = 25'd2;
        reg_plan[REG_MIN_RAW]     = 25'd1000;
        reg_plan[REG_MAX_RAW]     = 25'd999;
        apply_reg_plan();
        offer_pixel(16'd1000, 1'b0, 1'b0);
        offer_pixel(16'd999, 1'b0, 1'b0);
        offer_pixel(16'd0, 1'b0, 1'b1);
        drain_results();

        // zero step acts as one; single-value window checks both inclusive edges
        reg_plan[REG_SAMPLE_STEP] = 25'd0;
        reg_plan[REG_MIN_RAW]     = 25'd4242;
        reg_plan[REG_MAX_RAW]     = 25'd4242;
        apply_reg_plan();
        offer_pixel(16'd4241, 1'b0, 1'b0);
        offer_pixel(16'd4242, 1'b0, 1'b0);
        offer_pixel(16'd4243, 1'b1, 1'b1);
        drain_results();

        // random frames over several settings; the first two hold the register extremes
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            plan_random_setting();
            if (phase == 0)
            begin
                reg_plan[REG_SAMPLE_STEP] = 25'd255;
                reg_plan[REG_CENTER_X]    = 25'hFFFF;
                reg_plan[REG_CENTER_Y]    = 25'hFFFF;
                reg_plan[REG_X_GAIN]      = GAIN_ONE;
                reg_plan[REG_Y_GAIN]      = GAIN_ONE;
                reg_plan[REG_DEPTH_GAIN]  = GAIN_ONE;
                reg_plan[REG_MIN_RAW]     = 25'h0000;
                reg_plan[REG_MAX_RAW]     = 25'hFFFF;
            end
            else if (phase == 1)
            begin
                reg_plan[REG_SAMPLE_STEP] = 25'd1;
                reg_plan[REG_CENTER_X]    = 25'h0000;
                reg_plan[REG_CENTER_Y]    = 25'h0000;
                reg_plan[REG_X_GAIN]      = 25'd0;
                reg_plan[REG_Y_GAIN]      = 25'd0;
                reg_plan[REG_DEPTH_GAIN]  = 25'd0;
                reg_plan[REG_MIN_RAW]     = 25'hFFFF;
                reg_plan[REG_MAX_RAW]     = 25'hFFFF;
            end
            else if (phase == 2)
            begin
                // dense points so the long hold-off backs the block up
                reg_plan[REG_SAMPLE_STEP] = 25'd1;
                reg_plan[REG_MIN_RAW]     = 25'h0000;
                reg_plan[REG_MAX_RAW]     = 25'hFFFF;
            end
            apply_reg_plan();
            // some phases with no sender gaps at all
            max_gap = (phase % 3 == 1) ? 0 : 6;
            if (phase == 2)
            begin
                max_gap = 0;
                stall_requests++;
            end
            target = pixels_sent + PHASE_PIXELS;
            while (pixels_sent < target)
            begin
                width = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 12);
                send_frame(width, $urandom_range(1, 6));
            end
            drain_results();
        end

        $display("checked %0d pixels: %0d points, %0d frame ends, %0d of them short of points",
                 sb.pixels, sb.points, sb.frames, sb.short_frames);
        $display("%0d register settings incl. zero step, empty window, gain extremes, %s",
                 settings_applied, "long output stall");
        if (sb.errors == 0 && sb.pending_points.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
